>>> sv/gst_pkg.sv
// gst_pkg: shared codes and fixed field widths for the generational slot table.
// No dependencies; used by the channel interfaces and the top level.
package gst_pkg;

	localparam int SLOT_W   = 6;
	localparam int ACTION_W = 2;

	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd3;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_EXHAUSTED = 1'b1;

endpackage

>>> sv/gst_req_if.sv
// gst_req_if: request channel (valid/ready plus request payload).
// Depends on gst_pkg for the slot and action widths.
interface gst_req_if #(
	parameter int GEN_BITS   = 16,
	parameter int VALUE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic [gst_pkg::ACTION_W-1:0]  action;
	logic                          kind;
	logic [gst_pkg::SLOT_W-1:0]    handle_slot;
	logic [GEN_BITS-1:0]           handle_generation;
	logic [VALUE_BITS-1:0]         initial_value;
	logic [VALUE_BITS-1:0]         new_value;

	modport source (
		output valid, action, kind, handle_slot, handle_generation, initial_value, new_value,
		input  ready
	);
	modport sink (
		input  valid, action, kind, handle_slot, handle_generation, initial_value, new_value,
		output ready
	);
endinterface

>>> sv/gst_rsp_if.sv
// gst_rsp_if: response channel (valid/ready plus result payload).
// Depends on gst_pkg for the slot width.
interface gst_rsp_if #(
	parameter int GEN_BITS   = 16,
	parameter int VALUE_BITS = 32
);
	logic                        valid;
	logic                        ready;
	logic [gst_pkg::SLOT_W-1:0]  granted_slot;
	logic [GEN_BITS-1:0]         granted_generation;
	logic [VALUE_BITS-1:0]       read_value;
	logic                        status;

	modport source (
		output valid, granted_slot, granted_generation, read_value, status,
		input  ready
	);
	modport sink (
		input  valid, granted_slot, granted_generation, read_value, status,
		output ready
	);
endinterface

>>> sv/generational_slot_table.sv
// generational_slot_table: two-pool slot allocator with generation-checked value store.
// Depends on gst_pkg, gst_req_if, gst_rsp_if, gst_ram, gst_clear.
//
//   channel | dir | transaction
//   req     | in  | action, kind, handle_slot, handle_generation, initial_value, new_value
//   rsp     | out | granted_slot, granted_generation, read_value, status
//
// A transaction is accepted in ST_IDLE, where the accept edge issues the registered RAM reads;
// in ST_EXEC the write-back edge does the modify/write-back and loads the result register.
// After reset a sweep initializes every address of both RAMs;
// req.ready stays low meanwhile.
// If the result register is still full, the write-back cycle waits for rsp.ready.
module generational_slot_table #(
	parameter int SLOTS_PER_KIND = 64,
	parameter int GEN_BITS       = 16,
	parameter int VALUE_BITS     = 32
) (
	input logic    clk,
	input logic    arst_n,
	gst_req_if.sink   req,
	gst_rsp_if.source rsp
);
	localparam int IDX_W   = $clog2(SLOTS_PER_KIND);
	localparam int ADDR_W  = IDX_W + 1;
	localparam int DEPTH   = 2 ** ADDR_W;
	localparam int LINK_W  = $clog2(SLOTS_PER_KIND + 1);
	localparam int META_W  = LINK_W + GEN_BITS;
	localparam int STORE_W = 1 + GEN_BITS + VALUE_BITS;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOTS_PER_KIND);
	localparam logic [IDX_W:0]    SLOTS_X   = (IDX_W + 1)'(SLOTS_PER_KIND);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	logic                  clr_active;
	logic [ADDR_W-1:0]     clr_addr;

	logic [LINK_W-1:0]     head_q [2];

	logic [gst_pkg::ACTION_W-1:0] act_q;
	logic                  kind_q;
	logic                  inrange_q;
	logic                  empty_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [GEN_BITS-1:0]   gen_q;
	logic [VALUE_BITS-1:0] init_q;
	logic [VALUE_BITS-1:0] newv_q;

	logic                  rsp_valid_q;
	logic [gst_pkg::SLOT_W-1:0] out_slot_q;
	logic [GEN_BITS-1:0]   out_gen_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic                  out_status_q;

	logic                  acc;
	logic                  fire;
	logic [LINK_W-1:0]     head_cur;
	logic [IDX_W-1:0]      sidx;
	logic                  in_range;
	logic [ADDR_W-1:0]     rd_addr;

	logic [META_W-1:0]     meta_rdata;
	logic [STORE_W-1:0]    store_rdata;
	logic [LINK_W-1:0]     m_link;
	logic [GEN_BITS-1:0]   m_gen;
	logic                  s_bound;
	logic [GEN_BITS-1:0]   s_gen;
	logic [VALUE_BITS-1:0] s_val;
	logic                  match;

	logic                  meta_upd;
	logic [META_W-1:0]     meta_upd_data;
	logic                  store_upd;
	logic [STORE_W-1:0]    store_upd_data;
	logic                  head_upd;
	logic [LINK_W-1:0]     head_new;

	logic [gst_pkg::SLOT_W-1:0] res_slot;
	logic [GEN_BITS-1:0]   res_gen;
	logic [VALUE_BITS-1:0] res_val;
	logic                  res_status;

	logic [IDX_W:0]        clr_next;
	logic [LINK_W-1:0]     clr_link;

	logic                  meta_we;
	logic [ADDR_W-1:0]     meta_waddr;
	logic [META_W-1:0]     meta_wdata;
	logic                  store_we;
	logic [ADDR_W-1:0]     store_waddr;
	logic [STORE_W-1:0]    store_wdata;

	gst_clear #(.ADDR_W(ADDR_W)) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.active (clr_active),
		.addr   (clr_addr)
	);

	// accept side
	assign req.ready = (state_q == ST_IDLE) && !clr_active;
	assign acc       = req.valid && req.ready;
	assign head_cur  = head_q[req.kind];
	assign sidx      = IDX_W'(req.handle_slot);
	assign in_range  = 32'(req.handle_slot) < 32'(SLOTS_PER_KIND);
	assign rd_addr   = (req.action == gst_pkg::ACT_ALLOC) ?
	                   {req.kind, IDX_W'(head_cur)} : {req.kind, sidx};

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q     <= req.action;
			kind_q    <= req.kind;
			inrange_q <= in_range;
			empty_q   <= (head_cur == LINK_NULL);
			addr_q    <= rd_addr;
			gen_q     <= GEN_BITS'(req.handle_generation);
			init_q    <= VALUE_BITS'(req.initial_value);
			newv_q    <= VALUE_BITS'(req.new_value);
		end
	end

	// read-modify-write
	assign fire    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);
	assign m_link  = meta_rdata[META_W-1:GEN_BITS];
	assign m_gen   = meta_rdata[GEN_BITS-1:0];
	assign s_bound = store_rdata[STORE_W-1];
	assign s_gen   = store_rdata[GEN_BITS+VALUE_BITS-1:VALUE_BITS];
	assign s_val   = store_rdata[VALUE_BITS-1:0];
	assign match   = s_bound && (s_gen == gen_q);

	always_comb begin
		meta_upd       = 1'b0;
		meta_upd_data  = {LINK_NULL, m_gen};
		store_upd      = 1'b0;
		store_upd_data = {1'b1, gen_q, init_q};
		head_upd       = 1'b0;
		head_new       = m_link;
		res_slot       = '0;
		res_gen        = '0;
		res_val        = '0;
		res_status     = gst_pkg::STATUS_OK;
		case (act_q)
			gst_pkg::ACT_ALLOC: begin
				if (empty_q) begin
					res_status = gst_pkg::STATUS_EXHAUSTED;
				end else begin
					meta_upd = 1'b1;
					head_upd = 1'b1;
					res_slot = gst_pkg::SLOT_W'(addr_q[IDX_W-1:0]);
					res_gen  = m_gen;
				end
			end
			gst_pkg::ACT_RELEASE: begin
				if (inrange_q) begin
					meta_upd      = 1'b1;
					meta_upd_data = {head_q[kind_q], m_gen + GEN_BITS'(1)};
					head_upd      = 1'b1;
					head_new      = LINK_W'(addr_q[IDX_W-1:0]);
				end
			end
			gst_pkg::ACT_READ: begin
				res_val = init_q;
				if (inrange_q) begin
					if (match) begin
						res_val = s_val;
					end else begin
						store_upd = 1'b1;
					end
				end
			end
			gst_pkg::ACT_WRITE: begin
				res_val = init_q;
				if (inrange_q) begin
					store_upd      = 1'b1;
					store_upd_data = {1'b1, gen_q, newv_q};
					if (match) begin
						res_val = s_val;
					end
				end
			end
			default: begin
				res_status = gst_pkg::STATUS_OK;
			end
		endcase
	end

	// init sweep data: each slot links to the next, last to null
	assign clr_next = {1'b0, clr_addr[IDX_W-1:0]} + 1'b1;
	assign clr_link = (clr_next < SLOTS_X) ? LINK_W'(clr_next) : LINK_NULL;

	assign meta_we     = clr_active || (fire && meta_upd);
	assign meta_waddr  = clr_active ? clr_addr : addr_q;
	assign meta_wdata  = clr_active ? {clr_link, GEN_BITS'(0)} : meta_upd_data;
	assign store_we    = clr_active || (fire && store_upd);
	assign store_waddr = clr_active ? clr_addr : addr_q;
	assign store_wdata = clr_active ? STORE_W'(0) : store_upd_data;

	gst_ram #(.WIDTH(META_W), .DEPTH(DEPTH)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (acc),
		.raddr (rd_addr),
		.rdata (meta_rdata)
	);

	gst_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_store_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (store_wdata),
		.re    (acc),
		.raddr (rd_addr),
		.rdata (store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q[0]   <= '0;
			head_q[1]   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				state_q <= ST_EXEC;
			end else if (fire) begin
				state_q <= ST_IDLE;
			end
			if (fire && head_upd) begin
				head_q[kind_q] <= head_new;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_slot_q   <= res_slot;
			out_gen_q    <= res_gen;
			out_val_q    <= res_val;
			out_status_q <= res_status;
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.granted_slot       = out_slot_q;
	assign rsp.granted_generation = out_gen_q;
	assign rsp.read_value         = out_val_q;
	assign rsp.status             = out_status_q;

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !clr_active)
		else $error("request accepted during init sweep");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == ST_EXEC))
		else $error("accepted transaction did not enter write-back");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared without a write-back cycle");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q[0] <= LINK_NULL) && (head_q[1] <= LINK_NULL))
		else $error("free-list head beyond null link");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		(meta_we || store_we) |-> (clr_active || fire))
		else $error("RAM write outside sweep or write-back");
endmodule

>>> sv/gst_ram.sv
// gst_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module gst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> sv/gst_clear.sv
// gst_clear: post-reset sweep counter that walks every RAM address once.
// No dependencies; drives the initialization writes in the top level.
module gst_clear #(
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              active,
	output logic [ADDR_W-1:0] addr
);
	logic [ADDR_W:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (!cnt_q[ADDR_W]) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign active = !cnt_q[ADDR_W];
	assign addr   = cnt_q[ADDR_W-1:0];
endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for generational_slot_table, with an in-bench model of
// both pools (free lists, generations, value store). Depends on gst_pkg, gst_req_if,
// gst_rsp_if and the block's RTL.
module testbench;

	localparam int POOL_SLOTS = 64;
	localparam logic [6:0] LINK_END = 7'd64;

	typedef struct packed {
		logic [gst_pkg::ACTION_W-1:0] action;
		logic                         kind;
		logic [gst_pkg::SLOT_W-1:0]   slot;
		logic [15:0]                  gen;
		logic [31:0]                  init_val;
		logic [31:0]                  new_val;
	} table_req_t;

	typedef struct packed {
		logic [gst_pkg::SLOT_W-1:0] slot;
		logic [15:0]                gen;
		logic [31:0]                value;
		logic                       status;
	} table_rsp_t;

	logic clk;
	logic arst_n;

	gst_req_if #(.GEN_BITS(16), .VALUE_BITS(32)) req ();
	gst_rsp_if #(.GEN_BITS(16), .VALUE_BITS(32)) rsp ();

	generational_slot_table #(
		.SLOTS_PER_KIND(POOL_SLOTS),
		.GEN_BITS(16),
		.VALUE_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// model state
	logic [6:0]  free_link  [2][POOL_SLOTS];
	logic [6:0]  free_top   [2];
	logic [15:0] slot_gen   [2][POOL_SLOTS];
	logic [31:0] held_value [2][POOL_SLOTS];
	bit          held_valid [2][POOL_SLOTS];
	logic [15:0] held_gen   [2][POOL_SLOTS];
	// stimulus bookkeeping: slots handed out and not yet released
	bit          in_use     [2][POOL_SLOTS];
	int          in_use_cnt [2];

	table_rsp_t  pending_rsp [$];
	int          error_count;
	bit          idle_on;
	int          hold_request;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic reset_model();
		for (int k = 0; k < 2; k++) begin
			for (int s = 0; s < POOL_SLOTS; s++) begin
				free_link[k][s]  = (s + 1 < POOL_SLOTS) ? 7'(s + 1) : LINK_END;
				slot_gen[k][s]   = '0;
				held_valid[k][s] = 1'b0;
				held_gen[k][s]   = '0;
				in_use[k][s]     = 1'b0;
			end
			free_top[k]   = '0;
			in_use_cnt[k] = 0;
		end
	endtask

	function automatic table_rsp_t predict_table(table_req_t r);
		table_rsp_t o;
		logic [6:0] top;
		bit hit;
		o = '0;
		hit = held_valid[r.kind][r.slot] && (held_gen[r.kind][r.slot] == r.gen);
		case (r.action)
		gst_pkg::ACT_ALLOC: begin
			top = free_top[r.kind];
			if (top == LINK_END) begin
				o.status = gst_pkg::STATUS_EXHAUSTED;
			end else begin
				o.slot = top[5:0];
				o.gen = slot_gen[r.kind][top[5:0]];
				free_top[r.kind] = free_link[r.kind][top[5:0]];
				free_link[r.kind][top[5:0]] = LINK_END;
				if (!in_use[r.kind][top[5:0]]) begin
					in_use[r.kind][top[5:0]] = 1'b1;
					in_use_cnt[r.kind]++;
				end
			end
		end
		gst_pkg::ACT_RELEASE: begin
			free_link[r.kind][r.slot] = free_top[r.kind];
			slot_gen[r.kind][r.slot] = slot_gen[r.kind][r.slot] + 16'd1;
			free_top[r.kind] = {1'b0, r.slot};
			if (in_use[r.kind][r.slot]) begin
				in_use[r.kind][r.slot] = 1'b0;
				in_use_cnt[r.kind]--;
			end
		end
		gst_pkg::ACT_READ: begin
			if (hit) begin
				o.value = held_value[r.kind][r.slot];
			end else begin
				held_value[r.kind][r.slot] = r.init_val;
				held_gen[r.kind][r.slot]   = r.gen;
				held_valid[r.kind][r.slot] = 1'b1;
				o.value = r.init_val;
			end
		end
		default: begin
			o.value = hit ? held_value[r.kind][r.slot] : r.init_val;
			held_value[r.kind][r.slot] = r.new_val;
			held_gen[r.kind][r.slot]   = r.gen;
			held_valid[r.kind][r.slot] = 1'b1;
		end
		endcase
		return o;
	endfunction

	function automatic table_req_t make_req(logic [gst_pkg::ACTION_W-1:0] act, logic k,
			logic [gst_pkg::SLOT_W-1:0] s, logic [15:0] g, logic [31:0] iv,
			logic [31:0] nv);
		table_req_t r;
		r.action   = act;
		r.kind     = k;
		r.slot     = s;
		r.gen      = g;
		r.init_val = iv;
		r.new_val  = nv;
		return r;
	endfunction

	// mostly well-formed handles, some with a stale generation; the rest random slots and generations
	function automatic table_req_t random_req();
		table_req_t r;
		int pick;
		int alloc_pct;
		int s;
		r.kind     = 1'($urandom_range(1));
		r.slot     = 6'($urandom_range(63));
		r.gen      = 16'($urandom);
		r.init_val = $urandom;
		r.new_val  = $urandom;
		alloc_pct = (in_use_cnt[r.kind] > 48) ? 15 : 30;
		pick = $urandom_range(99);
		if (pick < alloc_pct)
			r.action = gst_pkg::ACT_ALLOC;
		else if (pick < alloc_pct + 22)
			r.action = gst_pkg::ACT_RELEASE;
		else if (pick < alloc_pct + 47)
			r.action = gst_pkg::ACT_READ;
		else
			r.action = gst_pkg::ACT_WRITE;
		if (r.action != gst_pkg::ACT_ALLOC && in_use_cnt[r.kind] > 0 &&
				$urandom_range(99) < 88) begin
			do
				s = $urandom_range(POOL_SLOTS - 1);
			while (!in_use[r.kind][s]);
			r.slot = s[5:0];
			if (r.action != gst_pkg::ACT_RELEASE) begin
				if ($urandom_range(99) < 85)
					r.gen = slot_gen[r.kind][s];
				else
					r.gen = slot_gen[r.kind][s] - 16'd1;
			end
		end
		return r;
	endfunction

	task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_item(table_req_t r);
		while (idle_on && $urandom_range(99) < 31) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid             <= 1'b1;
		req.action            <= r.action;
		req.kind              <= r.kind;
		req.handle_slot       <= r.slot;
		req.handle_generation <= r.gen;
		req.initial_value     <= r.init_val;
		req.new_value         <= r.new_val;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		pending_rsp.push_back(predict_table(r));
	endtask

	task automatic pause_until_drained();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		table_rsp_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				report_error("unexpected transaction", rsp.read_value, '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.granted_slot !== want.slot)
					report_error("granted_slot", 32'(rsp.granted_slot), 32'(want.slot));
				if (rsp.granted_generation !== want.gen)
					report_error("granted_generation", 32'(rsp.granted_generation),
						32'(want.gen));
				if (rsp.read_value !== want.value)
					report_error("read_value", rsp.read_value, want.value);
				if (rsp.status !== want.status)
					report_error("status", 32'(rsp.status), 32'(want.status));
			end
		end
	end

	// response ready, with random stalls and requested long hold-offs
	initial begin : rsp_ready_ctl
		int n;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				rsp.ready <= 1'b0;
				repeat (n - 1)
					@(posedge clk);
			end else if (idle_on && $urandom_range(99) < 31) begin
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic test_handle_checks();
		idle_on = 1'b1;
		send_item(make_req(gst_pkg::ACT_READ,  1'b0, 6'd0,  16'h0000, 32'h0000_0000, 32'h0));
		send_item(make_req(gst_pkg::ACT_READ,  1'b0, 6'd0,  16'h0000, 32'hFFFF_FFFF, 32'h0));
		send_item(make_req(gst_pkg::ACT_WRITE, 1'b0, 6'd0,  16'h0000, 32'h0000_1234,
			32'hFFFF_FFFF));
		send_item(make_req(gst_pkg::ACT_READ,  1'b0, 6'd0,  16'h0000, 32'h0000_0000, 32'h0));
		send_item(make_req(gst_pkg::ACT_READ,  1'b0, 6'd0,  16'hFFFF, 32'hA5A5_A5A5, 32'h0));
		send_item(make_req(gst_pkg::ACT_WRITE, 1'b0, 6'd0,  16'h0000, 32'h0000_0000,
			32'h5A5A_5A5A));
		send_item(make_req(gst_pkg::ACT_WRITE, 1'b1, 6'd63, 16'hFFFF, 32'hFFFF_FFFF,
			32'h0000_0000));
		send_item(make_req(gst_pkg::ACT_READ,  1'b1, 6'd63, 16'hFFFF, 32'h0000_0001,
			32'hFFFF_FFFF));
		send_item(make_req(gst_pkg::ACT_READ,  1'b0, 6'd63, 16'hFFFF, 32'h1357_9BDF, 32'h0));
		pause_until_drained();
	endtask

	task automatic test_alloc_release();
		idle_on = 1'b1;
		send_item(make_req(gst_pkg::ACT_ALLOC,   1'b0, 6'd0, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_ALLOC,   1'b1, 6'd0, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_ALLOC,   1'b0, 6'd0, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_RELEASE, 1'b0, 6'd0, 16'hBEEF, 32'hFFFF_FFFF, 32'h0));
		send_item(make_req(gst_pkg::ACT_ALLOC,   1'b0, 6'd0, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_READ,    1'b0, 6'd0, 16'h0001, 32'hC0DE_0001, 32'h0));
		// release of slot 1, then a second release of it while it is already free
		send_item(make_req(gst_pkg::ACT_RELEASE, 1'b0, 6'd1, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_RELEASE, 1'b0, 6'd1, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_ALLOC,   1'b0, 6'd0, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_ALLOC,   1'b0, 6'd0, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_ALLOC,   1'b0, 6'd0, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_RELEASE, 1'b0, 6'd2, 16'h0, 32'h0, 32'h0));
		send_item(make_req(gst_pkg::ACT_RELEASE, 1'b0, 6'd1, 16'h0, 32'h0, 32'h0));
		pause_until_drained();
	endtask

	task automatic test_pool_exhaustion();
		idle_on = 1'b1;
		while (free_top[1] != LINK_END)
			send_item(make_req(gst_pkg::ACT_ALLOC, 1'b1, 6'($urandom), 16'($urandom),
				$urandom, $urandom));
		send_item(make_req(gst_pkg::ACT_ALLOC, 1'b1, 6'd63, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_item(make_req(gst_pkg::ACT_ALLOC, 1'b1, 6'd0, 16'h0, 32'h0, 32'h0));
		for (int s = POOL_SLOTS - 1; s >= 0; s--) begin
			if (in_use[1][s])
				send_item(make_req(gst_pkg::ACT_RELEASE, 1'b1, s[5:0], 16'($urandom),
					$urandom, $urandom));
		end
		send_item(make_req(gst_pkg::ACT_ALLOC, 1'b1, 6'd0, 16'h0, 32'h0, 32'h0));
		pause_until_drained();
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_request = 300;
		repeat (40)
			send_item(random_req());
		pause_until_drained();
	endtask

	task automatic test_random_traffic(int count, bit with_idle);
		idle_on = with_idle;
		repeat (count)
			send_item(random_req());
		pause_until_drained();
	endtask

	initial begin
		error_count  = 0;
		idle_on      = 1'b0;
		hold_request = 0;
		reset_model();
		arst_n                <= 1'b0;
		req.valid             <= 1'b0;
		req.action            <= gst_pkg::ACT_ALLOC;
		req.kind              <= 1'b0;
		req.handle_slot       <= '0;
		req.handle_generation <= '0;
		req.initial_value     <= '0;
		req.new_value         <= '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		test_handle_checks();
		test_alloc_release();
		test_pool_exhaustion();
		test_backpressure();
		test_random_traffic(420, 1'b1);
		test_random_traffic(200, 1'b0);
		test_random_traffic(540, 1'b1);

		repeat (10)
			@(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
